// ----- hw/rtl/imm_pkg.sv -----
// shared types and codes of the integer matrix multiply unit
package imm_pkg;

	localparam int CFG_W = 4;
	localparam int IDX_W = 3;
	localparam int VALUE_W = 16;
	localparam int ACC_W = 32;
	localparam int REG_IDX_W = 2;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 40;
	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [1:0] {
		CMD_WRITE_A = 2'd0,
		CMD_WRITE_B = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROWS_A    = 2'd0,
		REG_INNER_DIM = 2'd1,
		REG_COLS_B    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic start;
		logic issue;
		logic emit;
	} imm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic k_last;
		logic pipe_busy;
		logic out_free;
		logic elem_last;
	} imm_sts_t;

endpackage

// ----- hw/rtl/integer_matrix_multiply_unit.sv -----
// top level of the integer matrix multiply unit
//
// Input stream carries commands: write an element of A, write an element of
// B, or compute C = A x B. Writes take one beat per cycle while the unit is
// idle and give no output. A compute beat makes the unit emit rows_a x cols_b
// beats of C (each dimension clamped to 1..MAX_DIM) in row-major order on the
// output stream, tlast on the final one. Dimensions come from the
// configuration port; the user must write it only while the unit is idle,
// and the unit itself does not enforce this. For each product element the
// unit issues one store read per cycle for the inner walk, then the read and
// multiply stages drain before the sum is loaded into the output register.
// The input is not ready while a compute beat runs. Sums wrap to 32 bits.
// Reset clears the controller, pipe valids and output valid and sets all
// dimensions to 8; the element stores are not cleared and must be written
// before they are used. When the receiver stalls, the finished element waits
// in the output register and the walk pauses before the next emit.
module integer_matrix_multiply_unit #(
	parameter int MAX_DIM = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [imm_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [imm_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// command[1:0], row_index[4:2], col_index[7:5], value[23:8]
	input  logic [imm_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// out_row[2:0], out_col[5:3], product[37:6], zero fill above
	output logic [imm_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	output logic                                  m_axis_tlast
);

	imm_pkg::imm_cmd_t cmd;
	imm_pkg::imm_sts_t sts;
	logic [imm_pkg::IDX_W-1:0] out_row, out_col;
	logic [imm_pkg::ACC_W-1:0] product;

	imm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.command  (s_axis_tdata[1:0]),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	imm_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_index (s_axis_tdata[4:2]),
		.col_index (s_axis_tdata[7:5]),
		.value     (s_axis_tdata[23:8]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, product, out_col, out_row};

endmodule

// ----- hw/rtl/imm_ram.sv -----
// generic single write port ram with registered read
module imm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/imm_ctrl.sv -----
// controller state machine of the matrix multiply unit
module imm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         command,
	input  imm_pkg::imm_sts_t  sts,
	output logic               in_ready,
	output imm_pkg::imm_cmd_t  cmd
);

	imm_pkg::state_t state_q, state_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		accept = 1'b0;
		cmd = '0;
		case (state_q)
			imm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				accept = in_valid;
				cmd.wr_a = accept && (command == imm_pkg::CMD_WRITE_A);
				cmd.wr_b = accept && (command == imm_pkg::CMD_WRITE_B);
				if (accept && (command == imm_pkg::CMD_COMPUTE)) begin
					cmd.start = 1'b1;
					state_d = imm_pkg::ST_MAC;
				end
			end
			imm_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
				if (sts.k_last) begin
					state_d = imm_pkg::ST_DRAIN;
				end
			end
			imm_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.elem_last ? imm_pkg::ST_IDLE : imm_pkg::ST_MAC;
				end
			end
			default: begin
				state_d = imm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/imm_datapath.sv -----
// element stores, index counters, multiply-accumulate pipe and result register
module imm_datapath #(
	parameter int MAX_DIM = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [imm_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [imm_pkg::CFG_W-1:0]           cfg_data,
	input  logic [imm_pkg::IDX_W-1:0]           row_index,
	input  logic [imm_pkg::IDX_W-1:0]           col_index,
	input  logic [imm_pkg::VALUE_W-1:0]         value,
	input  imm_pkg::imm_cmd_t                   cmd,
	output imm_pkg::imm_sts_t                   sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [imm_pkg::IDX_W-1:0]           out_row,
	output logic [imm_pkg::IDX_W-1:0]           out_col,
	output logic [imm_pkg::ACC_W-1:0]           product,
	output logic                                last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW = imm_pkg::CFG_W;

	logic [CW-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [CW-1:0] m_eff, n_eff, p_eff;
	logic [CW-1:0] i_q, j_q, k_q;
	logic          in_range;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic signed [31:0] value_ext;
	logic [ELEM_WIDTH-1:0] wdata, rd_a, rd_b;
	logic signed [31:0] a_ext, b_ext;
	logic               rd_vld_s1, mul_vld_s2;
	logic [imm_pkg::ACC_W-1:0] mul_s2, acc_q;
	logic [imm_pkg::IDX_W-1:0] out_row_q, out_col_q;
	logic [imm_pkg::ACC_W-1:0] product_q;
	logic out_valid_q, last_q;
	logic j_last;

	function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] d);
		logic [CW-1:0] r;
		if (d == '0) begin
			r = CW'(1);
		end else if (32'(d) > MAX_DIM) begin
			r = CW'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= imm_pkg::DIM_RESET;
			inner_dim_q <= imm_pkg::DIM_RESET;
			cols_b_q <= imm_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				imm_pkg::REG_ROWS_A:    rows_a_q <= cfg_data;
				imm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				imm_pkg::REG_COLS_B:    cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m_eff = clamp_dim(rows_a_q);
	assign n_eff = clamp_dim(inner_dim_q);
	assign p_eff = clamp_dim(cols_b_q);

	// element writes
	assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
	assign waddr = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
	assign value_ext = 32'(signed'(value));
	assign wdata = value_ext[ELEM_WIDTH-1:0];

	// reads walk A along row i and B along column j
	assign raddr_a = ADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign raddr_b = ADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));

	imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
		.clk   (clk),
		.we    (cmd.wr_a && in_range),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
		.clk   (clk),
		.we    (cmd.wr_b && in_range),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	assign j_last = (j_q == p_eff - CW'(1));

	// index counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.issue) begin
				k_q <= sts.k_last ? '0 : k_q + CW'(1);
			end
			if (cmd.emit) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + CW'(1);
				end else begin
					j_q <= j_q + CW'(1);
				end
			end
		end
	end

	// multiply-accumulate pipe
	assign a_ext = 32'(signed'(rd_a));
	assign b_ext = 32'(signed'(rd_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			mul_vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= imm_pkg::ACC_W'(a_ext * b_ext);
		if (cmd.start || cmd.emit) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + mul_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_row_q <= i_q[imm_pkg::IDX_W-1:0];
			out_col_q <= j_q[imm_pkg::IDX_W-1:0];
			product_q <= acc_q;
			last_q <= sts.elem_last;
		end
	end

	assign sts.k_last = (k_q == n_eff - CW'(1));
	assign sts.pipe_busy = rd_vld_s1 || mul_vld_s2;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.elem_last = j_last && (i_q == m_eff - CW'(1));

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign product = product_q;
	assign last = last_q;

endmodule
